>>> design/tts_pkg.sv
// Shared types and constants of the text terminal cell store.
// Holds action codes, register indexes and the packed beat layouts.
// No dependencies; imported by the top level and its checker.
package tts_pkg;

    // Grid limits and cell memory geometry
    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 32;
    localparam int CELL_DEPTH = 4096;
    localparam int CELL_AW    = 12;

    // Action codes
    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_SET   = 3'd2;
    localparam logic [2:0] ACT_HIDE  = 3'd3;
    localparam logic [2:0] ACT_FILL  = 3'd4;
    localparam logic [2:0] ACT_FETCH = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLS      = 2'd0;
    localparam logic [1:0] CFG_ROWS      = 2'd1;
    localparam logic [1:0] CFG_CODE_BITS = 2'd2;

    // Input beat payload, last field in the lowest bits
    typedef struct packed {
        logic [11:0] tile_offset;
        logic [15:0] char_value;
        logic [4:0]  row;
        logic [6:0]  col;
    } in_beat_t;

    // Result beat payload, last field in the lowest bits
    typedef struct packed {
        logic [11:0]       second_dirty;
        logic              second_dirty_valid;
        logic [11:0]       first_dirty;
        logic              dirty_valid;
        logic              bad_coord;
        logic signed [5:0] cursor_row;
        logic signed [7:0] cursor_col;
        logic              at_cursor;
        logic [14:0]       tile_color;
        logic [14:0]       tile_code;
        logic [15:0]       read_value;
    } out_beat_t;

endpackage

>>> design/text_terminal_cell_store.sv
// Character-cell store of a text terminal: cell memory, cursor and tile fetch.
// Depends on tts_pkg for action codes, register indexes and beat layouts.
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------------
//  s_        | in        | tuser: action; tdata: col, row, char_value, tile_offset
//  m_        | out       | tdata: out_beat_t (read_value .. second_dirty)
//  cfg_      | in        | cfg_addr: register index, cfg_wdata: value
//
// A write, read, cursor or fetch beat issues its cell memory read on acceptance;
// the registered data is compared or returned in the result state, where a changed
// cell is written back on the same port pair when the result is loaded.
// A fill writes min(cols*rows, 4096) cells, one cell written per cycle.
// Reset clears the cursor and sets the registers to their defaults; cells stay undefined until
// written. A result waiting on m_tready holds the block in its result state.
module text_terminal_cell_store (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // action
    input  logic [39:0] s_tdata,   // col, row, char_value, tile_offset
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_value, tile_code, tile_color, at_cursor, cursor_col, cursor_row,
    // bad_coord, dirty_valid, first_dirty, second_dirty_valid, second_dirty
    output logic [87:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import tts_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RESP = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;

    logic [15:0] cell_mem [CELL_DEPTH];

    logic [1:0]  state_reg, state_next;
    logic [7:0]  cols_reg;
    logic [5:0]  rows_reg;
    logic [3:0]  code_bits_reg;
    logic [6:0]  cur_col_reg;
    logic [4:0]  cur_line_reg;
    logic        cur_shown_reg;
    logic [2:0]  act_reg;
    logic        bad_reg;
    logic [CELL_AW-1:0] idx_reg;
    logic [6:0]  col_reg;
    logic [4:0]  row_reg;
    logic [15:0] val_reg;
    logic [15:0] rd_data_reg;
    logic [CELL_AW:0] fill_cnt_reg, fill_cnt_next;
    logic [CELL_AW:0] fill_limit_reg;
    out_beat_t   out_reg;
    logic        out_valid_reg;

    in_beat_t    in_beat;
    logic [7:0]  eff_cols;
    logic [5:0]  eff_rows;
    logic [13:0] grid_size;
    logic [CELL_AW:0] fill_limit;
    logic [12:0] in_lin;
    logic [12:0] cur_lin;
    logic        in_ok;
    logic        toff_ok;
    logic        cur_vis;
    logic        accept;
    logic        out_load;
    logic        mem_we;
    logic [CELL_AW-1:0] mem_wa;
    logic [15:0] code_mask;
    out_beat_t   res;

    assign in_beat = in_beat_t'(s_tdata);

    // Clamp the grid to its maximum size
    assign eff_cols  = ({1'b0, cols_reg} > 9'(MAX_COLS)) ? 8'(MAX_COLS) : cols_reg;
    assign eff_rows  = ({2'b0, rows_reg} > 8'(MAX_ROWS)) ? 6'(MAX_ROWS) : rows_reg;
    assign grid_size = 14'(eff_cols) * 14'(eff_rows);
    assign fill_limit = (grid_size > 14'(CELL_DEPTH)) ? (CELL_AW+1)'(CELL_DEPTH)
                                                      : grid_size[CELL_AW:0];

    // Linear cell offsets of the incoming beat and of the cursor
    assign in_lin  = 13'(in_beat.row) * 13'(eff_cols) + 13'(in_beat.col);
    assign cur_lin = 13'(cur_line_reg) * 13'(eff_cols) + 13'(cur_col_reg);
    assign in_ok   = ({1'b0, in_beat.col} < eff_cols) && ({1'b0, in_beat.row} < eff_rows);
    assign toff_ok = {2'b0, in_beat.tile_offset} < grid_size;
    assign cur_vis = cur_shown_reg && ({1'b0, cur_col_reg} < eff_cols)
                     && ({1'b0, cur_line_reg} < eff_rows);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_RESP) && (!out_valid_reg || m_tready);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg      <= 8'd80;
            rows_reg      <= 6'd24;
            code_bits_reg <= 4'd8;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_COLS:      cols_reg      <= cfg_wdata;
                CFG_ROWS:      rows_reg      <= cfg_wdata[5:0];
                CFG_CODE_BITS: code_bits_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Sequencer: idle, result, fill walk
    always_comb begin
        state_next    = state_reg;
        fill_cnt_next = fill_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    fill_cnt_next = '0;
                    state_next = (s_tuser == ACT_FILL && fill_limit != '0) ? ST_FILL
                                                                            : ST_RESP;
                end
            end
            ST_FILL: begin
                fill_cnt_next = fill_cnt_reg + 1'b1;
                if (fill_cnt_next == fill_limit_reg) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    // Capture the accepted beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg        <= s_tuser;
            col_reg        <= in_beat.col;
            row_reg        <= in_beat.row;
            val_reg        <= in_beat.char_value;
            fill_limit_reg <= fill_limit;
            if (s_tuser == ACT_FETCH) begin
                idx_reg <= in_beat.tile_offset;
                bad_reg <= !toff_ok;
            end else begin
                idx_reg <= in_lin[CELL_AW-1:0];
                bad_reg <= !in_ok && (s_tuser == ACT_WRITE || s_tuser == ACT_READ
                                      || s_tuser == ACT_SET);
            end
        end
    end

    // Cell memory: read on acceptance, write back or fill
    assign mem_we = (state_reg == ST_FILL)
                    || (out_load && act_reg == ACT_WRITE && !bad_reg && rd_data_reg != val_reg);
    assign mem_wa = (state_reg == ST_FILL) ? fill_cnt_reg[CELL_AW-1:0] : idx_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_wa] <= val_reg;
        end
        if (accept) begin
            rd_data_reg <= cell_mem[(s_tuser == ACT_FETCH) ? in_beat.tile_offset
                                                           : in_lin[CELL_AW-1:0]];
        end
    end

    // Form the result beat
    assign code_mask = (16'd1 << code_bits_reg) - 16'd1;

    always_comb begin
        logic       shown_after;
        logic [6:0] col_after;
        logic [4:0] line_after;
        res         = '0;
        shown_after = cur_shown_reg;
        col_after   = cur_col_reg;
        line_after  = cur_line_reg;
        res.bad_coord = bad_reg;
        if (!bad_reg) begin
            unique case (act_reg)
                ACT_WRITE: begin
                    if (rd_data_reg != val_reg) begin
                        res.dirty_valid = 1'b1;
                        res.first_dirty = idx_reg;
                    end
                end
                ACT_READ: res.read_value = rd_data_reg;
                ACT_SET: begin
                    if (cur_vis) begin
                        res.dirty_valid = 1'b1;
                        res.first_dirty = cur_lin[CELL_AW-1:0];
                    end
                    res.second_dirty_valid = 1'b1;
                    res.second_dirty       = idx_reg;
                    shown_after = 1'b1;
                    col_after   = col_reg;
                    line_after  = row_reg;
                end
                ACT_HIDE: begin
                    if (cur_vis) begin
                        res.dirty_valid = 1'b1;
                        res.first_dirty = cur_lin[CELL_AW-1:0];
                    end
                    shown_after = 1'b0;
                end
                ACT_FETCH: begin
                    res.read_value = rd_data_reg;
                    res.tile_code  = 15'(rd_data_reg & code_mask);
                    res.tile_color = 15'(rd_data_reg >> code_bits_reg);
                    res.at_cursor  = cur_vis && (idx_reg == cur_lin[CELL_AW-1:0]);
                end
                default: ;
            endcase
        end
        res.cursor_col = shown_after ? $signed({1'b0, col_after}) : -8'sd1;
        res.cursor_row = shown_after ? $signed({1'b0, line_after}) : -6'sd1;
    end

    // Cursor state advances with the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg   <= '0;
            cur_line_reg  <= '0;
            cur_shown_reg <= 1'b0;
        end else if (out_load && !bad_reg) begin
            if (act_reg == ACT_SET) begin
                cur_col_reg   <= col_reg;
                cur_line_reg  <= row_reg;
                cur_shown_reg <= 1'b1;
            end else if (act_reg == ACT_HIDE) begin
                cur_shown_reg <= 1'b0;
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

>>> design/tts_checker.sv
// Port-level checker of the text terminal cell store, bound to the top level.
// Depends on tts_pkg for the result beat layout.
module tts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);
    import tts_pkg::*;

    out_beat_t ob;
    assign ob = out_beat_t'(m_tdata);

    // A stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // An ignored action reports no data and no dirty tile
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ob.bad_coord |-> !ob.dirty_valid && !ob.second_dirty_valid
                                      && ob.read_value == 16'd0 && !ob.at_cursor)
        else $error("bad coordinate beat carries data");

    // A new cursor tile means the cursor is shown
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ob.second_dirty_valid |-> ob.cursor_col != -8'sd1
                                              && ob.cursor_row != -6'sd1)
        else $error("new cursor tile reported while hidden");

    // One beat at a time: no acceptance in the cycle after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a beat is in progress");

    // Reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind text_terminal_cell_store tts_checker u_tts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> verif/tb_top.sv
// Self-checking testbench for text_terminal_cell_store: directed table, then random phases.
// Depends on tts_pkg for action codes, register indexes and the s_/m_ beat layouts.
// A behavioural predictor of the cell store supplies each awaited result beat unless a directed row carries its own.
module tb_top;
    import tts_pkg::*;

    // Actions that the block must ignore
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES  = 600;

    typedef enum bit [2:0] {
        IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_PRESS
    } idle_mode_t;

    typedef enum bit {ROW_ITEM, ROW_GRID} row_kind_t;

    // One directed row. A grid row carries column_count in col, row_count in row
    // and code_bits in offset. A typed row carries its awaited result in the tail.
    typedef struct {
        row_kind_t   kind;
        logic [2:0]  act;
        int          col;
        int          row;
        logic [15:0] value;
        int          offset;
        bit          typed;
        logic [15:0] rd;
        logic [14:0] code;
        logic [14:0] color;
        bit          atc;
        int          ccol;
        int          crow;
        bit          bad;
        bit          dv;
        int          fd;
        bit          sdv;
        int          sd;
    } dir_row_t;

    typedef struct {
        int         cols;
        int         rows;
        int         code;
        idle_mode_t mode;
        int         items;
    } phase_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser   = '0;   // action
    logic [39:0] s_tdata   = '0;   // col, row, char_value, tile_offset
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // read_value, tile_code, tile_color, at_cursor, cursor_col, cursor_row,
    // bad_coord, dirty_valid, first_dirty, second_dirty_valid, second_dirty
    logic [87:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [7:0]  cfg_wdata = '0;

    idle_mode_t  idle_mode = IDLE_NONE;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          fail_count = 0;
    int          cycle_count = 0;

    // Shadow of the cell store
    bit [15:0]   shadow_cells [CELL_DEPTH];
    bit [6:0]    cur_col;
    bit [4:0]    cur_line;
    bit          cur_on;
    bit [7:0]    cols_reg = 8'd80;
    bit [5:0]    rows_reg = 6'd24;
    bit [3:0]    code_reg = 4'd8;

    out_beat_t   due_results [$];

    //  kind      action         col row  value     offs  t  rd        code  color at  cc  cr
    //                                                        bad dv fd  sdv sd
    dir_row_t directed_rows [30] = '{
        '{ROW_ITEM, ACT_HIDE,       0,  0, 16'h0000,    0, 1, 16'h0000,  'h0,  'h0, 0, -1, -1,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_READ,     127, 31, 16'h0000,    0, 1, 16'h0000,  'h0,  'h0, 0, -1, -1,
          1, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_FETCH,      0,  0, 16'h0000, 4095, 1, 16'h0000,  'h0,  'h0, 0, -1, -1,
          1, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_SET,       79, 23, 16'h0000,    0, 1, 16'h0000,  'h0,  'h0, 0, 79, 23,
          0, 0,    0, 1, 1919},
        '{ROW_ITEM, ACT_FILL,       0,  0, 16'hFFFF,    0, 1, 16'h0000,  'h0,  'h0, 0, 79, 23,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_FETCH,      0,  0, 16'h0000, 1919, 1, 16'hFFFF, 'hFF, 'hFF, 1, 79, 23,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_WRITE,      0,  0, 16'h1234,    0, 1, 16'h0000,  'h0,  'h0, 0, 79, 23,
          0, 1,    0, 0,    0},
        '{ROW_ITEM, ACT_WRITE,      0,  0, 16'h1234,    0, 1, 16'h0000,  'h0,  'h0, 0, 79, 23,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_READ,       0,  0, 16'h0000,    0, 1, 16'h1234,  'h0,  'h0, 0, 79, 23,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_SET,        0,  0, 16'h0000,    0, 1, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 1, 1919, 1,    0},
        '{ROW_ITEM, ACT_SPARE_LO, 127, 31, 16'hFFFF, 4095, 1, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_SPARE_HI, 127, 31, 16'hFFFF, 4095, 1, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_WRITE,     80,  0, 16'hFFFF,    0, 1, 16'h0000,  'h0,  'h0, 0,  0,  0,
          1, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_READ,       0, 24, 16'h0000,    0, 1, 16'h0000,  'h0,  'h0, 0,  0,  0,
          1, 0,    0, 0,    0},
        '{ROW_GRID, ACT_WRITE,    255, 63, 16'h0000,   15, 0, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_FILL,       0,  0, 16'h8001,    0, 0, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_FETCH,      0,  0, 16'h0000, 4095, 0, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_SET,      127, 31, 16'h0000,    0, 0, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_FETCH,      0,  0, 16'h0000, 4095, 0, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 0,    0},
        '{ROW_GRID, ACT_WRITE,    128, 32, 16'h0000,    0, 0, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_FETCH,      0,  0, 16'h0000, 4095, 0, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 0,    0},
        '{ROW_GRID, ACT_WRITE,      0, 24, 16'h0000,    8, 0, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_WRITE,      0,  0, 16'hFFFF,    0, 1, 16'h0000,  'h0,  'h0, 0, 127, 31,
          1, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_FETCH,      0,  0, 16'h0000,    0, 1, 16'h0000,  'h0,  'h0, 0, 127, 31,
          1, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_FILL,       0,  0, 16'h0000,    0, 1, 16'h0000,  'h0,  'h0, 0, 127, 31,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_HIDE,       0,  0, 16'h0000,    0, 1, 16'h0000,  'h0,  'h0, 0, -1, -1,
          0, 0,    0, 0,    0},
        '{ROW_GRID, ACT_WRITE,      1,  1, 16'h0000,    1, 0, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_READ,       0,  0, 16'h0000,    0, 1, 16'h8001,  'h0,  'h0, 0, -1, -1,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_FETCH,      0,  0, 16'h0000,    0, 0, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 0,    0},
        '{ROW_ITEM, ACT_SET,        0,  0, 16'h0000,    0, 1, 16'h0000,  'h0,  'h0, 0,  0,  0,
          0, 0,    0, 1,    0}
    };

    // Random phases: grid setting, idling pattern and number of beats
    phase_t phases [6] = '{
        '{ 80, 24,  8, IDLE_NONE,  350},
        '{128, 32,  4, IDLE_SEND,  350},
        '{ 17,  5, 12, IDLE_RECV,  350},
        '{255, 63, 15, IDLE_BOTH,  350},
        '{  1, 32,  0, IDLE_PRESS, 200},
        '{128,  1,  1, IDLE_NONE,  300}
    };

    text_terminal_cell_store dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned grid_cols();
        return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    function automatic int unsigned grid_rows();
        return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function automatic bit on_grid(input int unsigned c, input int unsigned r);
        return c < grid_cols() && r < grid_rows();
    endfunction

    function automatic int unsigned tile_of(input int unsigned c, input int unsigned r);
        return (r * grid_cols() + c) & (CELL_DEPTH - 1);
    endfunction

    // Cursor shown and still inside the grid as currently sized
    function automatic bit cursor_on_grid();
        return cur_on && on_grid(cur_col, cur_line);
    endfunction

    function automatic int sender_gap_pct();
        case (idle_mode)
            IDLE_SEND: return 59;
            IDLE_BOTH: return 30;
            default:   return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mode)
            IDLE_RECV:  return 59;
            IDLE_BOTH,
            IDLE_PRESS: return 30;
            default:    return 0;
        endcase
    endfunction

    // Apply one action to the shadow store and return the result beat it gives
    function automatic out_beat_t predict_terminal_step(input logic [2:0] act,
                                                        input in_beat_t b);
        out_beat_t   r;
        int unsigned span;
        int unsigned idx;
        int unsigned cell_word;
        int unsigned k;
        r = '0;
        span = grid_cols() * grid_rows();
        case (act)
            ACT_WRITE: begin
                if (!on_grid(b.col, b.row)) begin
                    r.bad_coord = 1'b1;
                end else begin
                    idx = tile_of(b.col, b.row);
                    if (shadow_cells[idx] != b.char_value) begin
                        shadow_cells[idx] = b.char_value;
                        r.dirty_valid = 1'b1;
                        r.first_dirty = 12'(idx);
                    end
                end
            end
            ACT_READ: begin
                if (!on_grid(b.col, b.row))
                    r.bad_coord = 1'b1;
                else
                    r.read_value = shadow_cells[tile_of(b.col, b.row)];
            end
            ACT_SET: begin
                if (!on_grid(b.col, b.row)) begin
                    r.bad_coord = 1'b1;
                end else begin
                    if (cursor_on_grid()) begin
                        r.dirty_valid = 1'b1;
                        r.first_dirty = 12'(tile_of(cur_col, cur_line));
                    end
                    cur_col = b.col;
                    cur_line = b.row;
                    cur_on = 1'b1;
                    r.second_dirty_valid = 1'b1;
                    r.second_dirty = 12'(tile_of(b.col, b.row));
                end
            end
            ACT_HIDE: begin
                if (cursor_on_grid()) begin
                    r.dirty_valid = 1'b1;
                    r.first_dirty = 12'(tile_of(cur_col, cur_line));
                end
                cur_on = 1'b0;
            end
            ACT_FILL: begin
                for (k = 0; k < span && k < CELL_DEPTH; k++)
                    shadow_cells[k] = b.char_value;
            end
            ACT_FETCH: begin
                if (b.tile_offset >= span) begin
                    r.bad_coord = 1'b1;
                end else begin
                    cell_word = shadow_cells[b.tile_offset];
                    r.read_value = 16'(cell_word);
                    r.tile_code = 15'(cell_word & ((1 << code_reg) - 1));
                    r.tile_color = 15'(cell_word >> code_reg);
                    r.at_cursor = cursor_on_grid() &&
                                  b.tile_offset == 12'(tile_of(cur_col, cur_line));
                end
            end
            default: ;
        endcase
        if (cur_on) begin
            r.cursor_col = 8'({1'b0, cur_col});
            r.cursor_row = 6'({1'b0, cur_line});
        end else begin
            r.cursor_col = '1;
            r.cursor_row = '1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Offer one input beat, hold it until taken, then record what it should give
    task automatic send_beat(input logic [2:0] act, input in_beat_t b, input bit typed,
                             input out_beat_t typed_want);
        out_beat_t want;
        while ($urandom_range(99) < sender_gap_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        want = predict_terminal_step(act, b);
        due_results.push_back(typed ? typed_want : want);
    endtask

    // Drain every awaited result, then write all three registers back to back
    task automatic apply_grid(input int cols, input int rows, input int code);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_COLS;
        cfg_wdata <= 8'(cols);
        @(posedge aclk);
        cfg_addr <= CFG_ROWS;
        cfg_wdata <= 8'(rows);
        @(posedge aclk);
        cfg_addr <= CFG_CODE_BITS;
        cfg_wdata <= 8'(code);
        @(posedge aclk);
        cfg_we <= 1'b0;
        cols_reg = 8'(cols);
        rows_reg = 6'(rows);
        code_reg = 4'(code);
    endtask

    // Mostly in-grid accesses, some same-value writes and cursor-tile fetches
    task automatic make_random_item(output logic [2:0] act, output in_beat_t b);
        int unsigned pick;
        int unsigned ec;
        int unsigned er;
        int unsigned span;
        b = in_beat_t'(40'({$urandom, $urandom}));
        ec = grid_cols();
        er = grid_rows();
        span = ec * er;
        pick = $urandom_range(999);
        if (pick < 300)
            act = ACT_WRITE;
        else if (pick < 450)
            act = ACT_READ;
        else if (pick < 570)
            act = ACT_SET;
        else if (pick < 620)
            act = ACT_HIDE;
        else if (pick < 635)
            act = ACT_FILL;
        else if (pick < 970)
            act = ACT_FETCH;
        else
            act = ($urandom_range(1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
        if (span != 0 && $urandom_range(9) < 8) begin
            b.col = 7'($urandom_range(ec - 1));
            b.row = 5'($urandom_range(er - 1));
            if (act == ACT_WRITE && $urandom_range(9) < 3)
                b.char_value = shadow_cells[tile_of(b.col, b.row)];
            if (cursor_on_grid() && $urandom_range(3) == 0)
                b.tile_offset = 12'(tile_of(cur_col, cur_line));
            else
                b.tile_offset = 12'($urandom_range(span - 1));
        end
    endtask

    // Receiver: one long hold-off in the pressure phase, random stalls otherwise
    always @(posedge aclk) begin
        if (idle_mode == IDLE_PRESS && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    // Compare each taken result beat with the oldest awaited one
    always @(posedge aclk) begin : result_check
        out_beat_t got;
        out_beat_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got = m_tdata;
            if (due_results.size() == 0) begin
                $display("%0t: result beat with none awaited, expected nothing got %h",
                         $time, m_tdata);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                check_field("read_value", want.read_value, got.read_value);
                check_field("tile_code", want.tile_code, got.tile_code);
                check_field("tile_color", want.tile_color, got.tile_color);
                check_field("at_cursor", want.at_cursor, got.at_cursor);
                check_field("cursor_col", want.cursor_col, got.cursor_col);
                check_field("cursor_row", want.cursor_row, got.cursor_row);
                check_field("bad_coord", want.bad_coord, got.bad_coord);
                check_field("dirty_valid", want.dirty_valid, got.dirty_valid);
                check_field("first_dirty", want.first_dirty, got.first_dirty);
                check_field("second_dirty_valid", want.second_dirty_valid,
                            got.second_dirty_valid);
                check_field("second_dirty", want.second_dirty, got.second_dirty);
            end
        end
    end

    // Guard against a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t   rw;
        logic [2:0] act;
        in_beat_t   b;
        out_beat_t  want;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (directed_rows[i]) begin
            rw = directed_rows[i];
            if (rw.kind == ROW_GRID) begin
                apply_grid(rw.col, rw.row, rw.offset);
            end else begin
                b.col = 7'(rw.col);
                b.row = 5'(rw.row);
                b.char_value = rw.value;
                b.tile_offset = 12'(rw.offset);
                want = '{read_value: rw.rd, tile_code: rw.code, tile_color: rw.color,
                         at_cursor: rw.atc, cursor_col: 8'(rw.ccol), cursor_row: 6'(rw.crow),
                         bad_coord: rw.bad, dirty_valid: rw.dv, first_dirty: 12'(rw.fd),
                         second_dirty_valid: rw.sdv, second_dirty: 12'(rw.sd)};
                send_beat(rw.act, b, rw.typed, want);
            end
        end

        // Random phases
        foreach (phases[p]) begin
            apply_grid(phases[p].cols, phases[p].rows, phases[p].code);
            idle_mode <= phases[p].mode;
            repeat (phases[p].items) begin
                make_random_item(act, b);
                send_beat(act, b, 1'b0, '0);
            end
        end

        // Drop valid, wait out the awaited results and a short tail
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
